@@ rtl/rme_pkg.sv @@
// shared constants, types and functions for the rotation matrix to euler block
package rme_pkg;

  localparam int CordicStages = 16;
  localparam int CordicW      = 32;   // vector datapath width
  localparam int AngW         = 33;   // Q2.30 accumulator plus sign room
  localparam int SqrtSteps    = 24;   // result bits of the square root

  localparam logic signed [AngW-1:0] HalfPiQ30 = 33'sd1686629713;
  localparam logic signed [15:0] PiQ13     = 16'sd25736;
  localparam logic signed [15:0] HalfPiQ13 = 16'sd12868;
  localparam logic [14:0] PoleThresholdReset = 15'd16351;

  localparam logic [1:0] ModeRegular = 2'd0;
  localparam logic [1:0] ModeNorth   = 2'd1;
  localparam logic [1:0] ModeSouth   = 2'd2;

  localparam logic [1:0] RegPoleThreshold = 2'd0;

  // atan(2^-i) in Q2.30, truncated
  function automatic logic signed [AngW-1:0] stage_angle(input int i);
    logic signed [AngW-1:0] a;
    a = '0;
    unique case (i)
      0: a = 33'sd843314856;
      1: a = 33'sd497837829;
      2: a = 33'sd263043836;
      3: a = 33'sd133525158;
      4: a = 33'sd67021686;
      5: a = 33'sd33543515;
      6: a = 33'sd16775850;
      7: a = 33'sd8388437;
      8: a = 33'sd4194282;
      9: a = 33'sd2097149;
      default: a = (33'sd1 <<< (30 - i)) - 33'sd1;
    endcase
    return a;
  endfunction

  typedef struct packed {
    logic signed [CordicW-1:0] x;
    logic signed [CordicW-1:0] y;
    logic signed [AngW-1:0]    z;
    logic                      zero;
  } rme_vec_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  mode;
    logic signed [15:0] r10;
    logic signed [15:0] r02;
    logic signed [15:0] r22;
    logic signed [15:0] r12;
    logic signed [15:0] r11;
    logic signed [15:0] r20;
    logic signed [15:0] r00;
  } rme_side_t;

endpackage

@@ rtl/rotation_matrix_to_euler.sv @@
// top level: rotation matrix entries in, euler angles out
// Usage: feed seven Q2.14 matrix entries on the in_ channel; one result of
// three Q3.13 angles and a branch code leaves on the out_ channel per item.
// Pipeline: 1 input register, 1 square root load register, 24 square root
// steps, 1 cordic prescale, 16 cordic stages, 1 rounding stage and the output
// register, 45 register stages.
// Throughput: one item per cycle unless the receiver stalls; the square root
// of the asin path is a restoring root unrolled over 24 register stages, one
// result bit each, and the three atan2 units are 16-stage pipelines.
// The whole pipe advances together; it moves when the output register is
// empty or being drained, so in_tready follows out_tready or a free slot.
// A receiver stall freezes every stage; nothing is lost or repeated.
// Reset clears all valid bits and sets pole_threshold to 16351 (0.998).
// pole_threshold is written through cfg_ at byte address 0 and may only be
// changed while no item is in flight.
module rotation_matrix_to_euler (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,   // r00, r02, r10, r11, r12, r20, r22
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [47:0]  out_tdata,  // angle_x, angle_y, angle_z, 1'b0
  output logic [1:0]   out_tuser,  // branch_mode
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int SQ = rme_pkg::SqrtSteps;
  localparam int CS = rme_pkg::CordicStages;

  logic [14:0] thr_r;
  logic        en;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == rme_pkg::RegPoleThreshold[0]) ? {17'd0, thr_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= rme_pkg::PoleThresholdReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr[2] == rme_pkg::RegPoleThreshold[0]) begin
      thr_r <= cfg_pwdata[14:0];
    end
  end

  logic out_valid_r;
  assign en = !out_valid_r || out_tready;
  assign in_tready = en;

  // input register with branch decision
  rme_pkg::rme_side_t s0_r;
  rme_pkg::rme_side_t s0_nxt;
  always_comb begin
    logic signed [16:0] th;
    s0_nxt.valid = in_tvalid;
    s0_nxt.r00 = in_tdata[15:0];
    s0_nxt.r02 = in_tdata[31:16];
    s0_nxt.r10 = in_tdata[47:32];
    s0_nxt.r11 = in_tdata[63:48];
    s0_nxt.r12 = in_tdata[79:64];
    s0_nxt.r20 = in_tdata[95:80];
    s0_nxt.r22 = in_tdata[111:96];
    th = {2'b00, thr_r};
    if (17'(s0_nxt.r10) > th) s0_nxt.mode = rme_pkg::ModeNorth;
    else if (17'(s0_nxt.r10) < -th) s0_nxt.mode = rme_pkg::ModeSouth;
    else s0_nxt.mode = rme_pkg::ModeRegular;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s0_r.valid <= 1'b0;
    else if (en) s0_r.valid <= s0_nxt.valid;
    if (en) begin
      s0_r.mode <= s0_nxt.mode;
      s0_r.r00 <= s0_nxt.r00; s0_r.r02 <= s0_nxt.r02; s0_r.r10 <= s0_nxt.r10;
      s0_r.r11 <= s0_nxt.r11; s0_r.r12 <= s0_nxt.r12; s0_r.r20 <= s0_nxt.r20;
      s0_r.r22 <= s0_nxt.r22;
    end
  end

  // restoring square root of d*256, d = 2^28 - v*v clamped at 0
  logic [37:0] rem_r [SQ+1];
  logic [23:0] root_r [SQ+1];
  logic [47:0] rad_r [SQ+1];
  rme_pkg::rme_side_t sq_r [SQ+1];
  logic [47:0] rad0;
  always_comb begin
    logic signed [32:0] vv;
    logic signed [33:0] d;
    vv = 33'(32'(s0_r.r10) * 32'(s0_r.r10));
    d = 34'sd268435456 - 34'(vv);
    rad0 = d[33] ? 48'd0 : {d[31:0], 8'd0} << 8;
  end
  // radicand is d<<8 held in bits [47:8] of a 48-bit word for 24 steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= SQ; k++) sq_r[k].valid <= 1'b0;
    end else if (en) begin
      sq_r[0].valid <= s0_r.valid;
      for (int k = 0; k < SQ; k++) sq_r[k+1].valid <= sq_r[k].valid;
    end
    if (en) begin
      rem_r[0] <= '0;
      root_r[0] <= '0;
      rad_r[0] <= rad0 >> 8;
      sq_r[0].mode <= s0_r.mode;
      sq_r[0].r00 <= s0_r.r00; sq_r[0].r02 <= s0_r.r02; sq_r[0].r10 <= s0_r.r10;
      sq_r[0].r11 <= s0_r.r11; sq_r[0].r12 <= s0_r.r12; sq_r[0].r20 <= s0_r.r20;
      sq_r[0].r22 <= s0_r.r22;
      for (int k = 0; k < SQ; k++) begin
        logic [37:0] rm;
        logic [37:0] tr;
        rm = {rem_r[k][35:0], rad_r[k][47:46]};
        tr = {12'd0, root_r[k], 2'b01};
        if (rm >= tr) begin
          rem_r[k+1] <= rm - tr;
          root_r[k+1] <= {root_r[k][22:0], 1'b1};
        end else begin
          rem_r[k+1] <= rm;
          root_r[k+1] <= {root_r[k][22:0], 1'b0};
        end
        rad_r[k+1] <= rad_r[k] << 2;
        sq_r[k+1].mode <= sq_r[k].mode;
        sq_r[k+1].r00 <= sq_r[k].r00; sq_r[k+1].r02 <= sq_r[k].r02;
        sq_r[k+1].r10 <= sq_r[k].r10; sq_r[k+1].r11 <= sq_r[k].r11;
        sq_r[k+1].r12 <= sq_r[k].r12; sq_r[k+1].r20 <= sq_r[k].r20;
        sq_r[k+1].r22 <= sq_r[k].r22;
      end
    end
  end

  rme_pkg::rme_side_t sl;
  assign sl = sq_r[SQ];
  logic [1:0]  md_r [CS+2];
  logic        vd_r [CS+2];
  logic signed [22:0] xa_y, xa_x, ya_y, ya_x, za_y, za_x;
  logic signed [15:0] ang_x, ang_y, ang_z;

  always_comb begin
    xa_y = -23'(sl.r12);
    xa_x = 23'(sl.r11);
    ya_y = 23'(sl.r10) <<< 4;
    ya_x = {1'b0, 22'(root_r[SQ])};
    if (sl.mode == rme_pkg::ModeRegular) begin
      za_y = -23'(sl.r20);
      za_x = 23'(sl.r00);
    end else begin
      za_y = 23'(sl.r02);
      za_x = 23'(sl.r22);
    end
  end

  rme_cordic u_cx (.clk(clk), .en(en), .y_in(xa_y), .x_in(xa_x), .ang_out(ang_x));
  rme_cordic u_cy (.clk(clk), .en(en), .y_in(ya_y), .x_in(ya_x), .ang_out(ang_y));
  rme_cordic u_cz (.clk(clk), .en(en), .y_in(za_y), .x_in(za_x), .ang_out(ang_z));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CS + 2; k++) vd_r[k] <= 1'b0;
    end else if (en) begin
      vd_r[0] <= sl.valid;
      for (int k = 0; k < CS + 1; k++) vd_r[k+1] <= vd_r[k];
    end
    if (en) begin
      md_r[0] <= sl.mode;
      for (int k = 0; k < CS + 1; k++) md_r[k+1] <= md_r[k];
    end
  end

  logic signed [15:0] ay_sat;
  always_comb begin
    ay_sat = ang_y;
    if (ang_y > rme_pkg::HalfPiQ13) ay_sat = rme_pkg::HalfPiQ13;
    if (ang_y < -rme_pkg::HalfPiQ13) ay_sat = -rme_pkg::HalfPiQ13;
  end

  logic [47:0] out_data_r;
  logic [1:0]  out_mode_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= vd_r[CS+1];
    if (en) begin
      out_mode_r <= md_r[CS+1];
      unique case (md_r[CS+1])
        rme_pkg::ModeNorth:
          out_data_r <= {1'b0, ang_z, rme_pkg::HalfPiQ13[14:0], 16'd0};
        rme_pkg::ModeSouth:
          out_data_r <= {1'b0, ang_z, 15'(-rme_pkg::HalfPiQ13), 16'd0};
        default:
          out_data_r <= {1'b0, ang_z, ay_sat[14:0], ang_x};
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_mode_r;

endmodule

@@ rtl/rme_cordic.sv @@
// pipelined cordic atan2 in vectoring mode, one stage per register
module rme_cordic (
  input  logic                clk,
  input  logic                en,
  input  logic signed [22:0]  y_in,   // already scaled operands
  input  logic signed [22:0]  x_in,
  output logic signed [15:0]  ang_out // q3.13, saturated to pi
);

  localparam int N = rme_pkg::CordicStages;
  localparam int W = rme_pkg::CordicW;

  rme_pkg::rme_vec_t pre_nxt;
  rme_pkg::rme_vec_t stg_r [N+1];
  rme_pkg::rme_vec_t stg_nxt [N];
  logic signed [rme_pkg::AngW-1:0] zr;
  logic signed [rme_pkg::AngW-1:0] zs;
  logic signed [15:0] ang_nxt;
  logic signed [15:0] ang_r;

  always_comb begin
    logic signed [W-1:0] xs;
    logic signed [W-1:0] ys;
    xs = W'(x_in) <<< 8;
    ys = W'(y_in) <<< 8;
    pre_nxt.zero = (x_in == '0) && (y_in == '0);
    pre_nxt.x = xs;
    pre_nxt.y = ys;
    pre_nxt.z = '0;
    if (xs < 0) begin
      if (ys >= 0) begin
        pre_nxt.x = ys;
        pre_nxt.y = -xs;
        pre_nxt.z = rme_pkg::HalfPiQ30;
      end else begin
        pre_nxt.x = -ys;
        pre_nxt.y = xs;
        pre_nxt.z = -rme_pkg::HalfPiQ30;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_comb begin
      stg_nxt[i] = stg_r[i];
      if (stg_r[i].y >= 0) begin
        stg_nxt[i].x = stg_r[i].x + (stg_r[i].y >>> i);
        stg_nxt[i].y = stg_r[i].y - (stg_r[i].x >>> i);
        stg_nxt[i].z = stg_r[i].z + rme_pkg::stage_angle(i);
      end else begin
        stg_nxt[i].x = stg_r[i].x - (stg_r[i].y >>> i);
        stg_nxt[i].y = stg_r[i].y + (stg_r[i].x >>> i);
        stg_nxt[i].z = stg_r[i].z - rme_pkg::stage_angle(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg_r[0] <= pre_nxt;
      for (int i = 0; i < N; i++) stg_r[i+1] <= stg_nxt[i];
      ang_r <= ang_nxt;
    end
  end

  always_comb begin
    zr = (stg_r[N].z + rme_pkg::AngW'(65536)) >>> 17;
    zs = zr;
    if (zr > rme_pkg::AngW'(rme_pkg::PiQ13)) zs = rme_pkg::AngW'(rme_pkg::PiQ13);
    if (zr < -rme_pkg::AngW'(rme_pkg::PiQ13)) zs = -rme_pkg::AngW'(rme_pkg::PiQ13);
    ang_nxt = stg_r[N].zero ? 16'sd0 : zs[15:0];
  end

  assign ang_out = ang_r;

endmodule

@@ rtl/rme_checker.sv @@
// port-level checker for the rotation matrix to euler block
module rme_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [1:0]  out_tuser
);
  a_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == rme_pkg::ModeRegular || out_tuser == rme_pkg::ModeNorth ||
                    out_tuser == rme_pkg::ModeSouth)) else $error("bad branch code");
  a_pole_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != rme_pkg::ModeRegular |-> out_tdata[15:0] == 16'd0)
    else $error("pole transfer with nonzero x");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready) else $error("input blocked with empty output");
endmodule

bind rotation_matrix_to_euler rme_port_checker u_rme_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata), .out_tuser(out_tuser)
);

@@ tb/rme_checker.sv @@
// checker for rotation_matrix_to_euler: watches the channels, predicts angles, compares
`timescale 1ns / 100ps
module rme_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [111:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [47:0]  out_tdata,
  input  logic [1:0]   out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  input  logic         cfg_pready,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic [15:0] ax;
    logic [14:0] ay;
    logic [15:0] az;
    logic [1:0]  mode;
  } angles_t;

  angles_t     angles_q[$];
  logic [14:0] pole_th;

  localparam longint HalfPiFine = 64'sd1686629713;
  longint atan_tab [10] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                            33543515, 16775850, 8388437, 4194282, 2097149};

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // vectoring cordic, angle in Q3.13
  function automatic longint vec_angle(longint y, longint x);
    longint acc, t, a, dx, dy;
    acc = 0;
    if (y == 0 && x == 0) return 0;
    y = y * 256;
    x = x * 256;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; acc = HalfPiFine;
      end else begin
        x = -y; y = t; acc = -HalfPiFine;
      end
    end
    for (int i = 0; i < 16; i++) begin
      a = (i < 10) ? atan_tab[i] : ((64'sd1 << (30 - i)) - 1);
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; acc += a;
      end else begin
        x -= dx; y += dy; acc -= a;
      end
    end
    return clip((acc + 65536) >>> 17, longint'(rme_pkg::PiQ13));
  endfunction

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint asin_angle(longint v);
    longint d;
    d = (64'sd1 <<< 28) - v * v;
    if (d < 0) d = 0;
    return clip(vec_angle(v * 16, longint'(int_root(longint'(d) << 8))),
                longint'(rme_pkg::HalfPiQ13));
  endfunction

  function automatic angles_t predict_angles(logic [111:0] d, logic [14:0] th);
    longint r00, r02, r10, r11, r12, r20, r22, lim;
    angles_t e;
    r00 = longint'($signed(d[15:0]));
    r02 = longint'($signed(d[31:16]));
    r10 = longint'($signed(d[47:32]));
    r11 = longint'($signed(d[63:48]));
    r12 = longint'($signed(d[79:64]));
    r20 = longint'($signed(d[95:80]));
    r22 = longint'($signed(d[111:96]));
    lim = longint'(th);
    if (r10 > lim || r10 < -lim) begin
      e.ax = '0;
      e.ay = (r10 > lim) ? rme_pkg::HalfPiQ13[14:0] : 15'(-longint'(rme_pkg::HalfPiQ13));
      e.az = 16'(vec_angle(r02, r22));
      e.mode = (r10 > lim) ? rme_pkg::ModeNorth : rme_pkg::ModeSouth;
    end else begin
      e.ax = 16'(vec_angle(-r12, r11));
      e.ay = 15'(asin_angle(r10));
      e.az = 16'(vec_angle(-r20, r00));
      e.mode = rme_pkg::ModeRegular;
    end
    return e;
  endfunction

  always @(posedge clk) begin
    angles_t e;
    if (!rst_n) begin
      pole_th <= rme_pkg::PoleThresholdReset;
      angles_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[2] == rme_pkg::RegPoleThreshold[0])
        pole_th <= cfg_pwdata[14:0];
      if (in_tvalid && in_tready)
        angles_q.push_back(predict_angles(in_tdata, pole_th));
      if (out_tvalid && out_tready) begin
        if (angles_q.size() == 0) begin
          $error("result transfer with no expectation waiting");
          fail_count <= fail_count + 1;
        end else begin
          e = angles_q.pop_front();
          if (out_tdata[15:0] !== e.ax || out_tdata[30:16] !== e.ay ||
              out_tdata[46:31] !== e.az || out_tuser !== e.mode)
            fail_count <= fail_count + 1;
          if (out_tdata[15:0] !== e.ax)
            $error("angle_x expected %0d got %0d", $signed(e.ax), $signed(out_tdata[15:0]));
          if (out_tdata[30:16] !== e.ay)
            $error("angle_y expected %0d got %0d", $signed(e.ay),
                   $signed(out_tdata[30:16]));
          if (out_tdata[46:31] !== e.az)
            $error("angle_z expected %0d got %0d", $signed(e.az),
                   $signed(out_tdata[46:31]));
          if (out_tuser !== e.mode)
            $error("branch_mode expected %0d got %0d", e.mode, out_tuser);
        end
      end
    end
  end

  assign pending = angles_q.size();

endmodule

@@ tb/tb_top.sv @@
// testbench top for rotation_matrix_to_euler: stimulus, receiver stalls and verdict
`timescale 1ns / 100ps
module tb_top;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [111:0] in_tdata = '0;   // r00, r02, r10, r11, r12, r20, r22
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [47:0]  out_tdata;       // angle_x, angle_y, angle_z, pad
  logic [1:0]   out_tuser;       // branch_mode
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [2:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;
  int           fail_count;
  int           pending;
  bit           tx_busy, rx_busy;   // when clear that side never idles
  int           rx_wait;
  int           quiet_cycles;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  rotation_matrix_to_euler dut (.*);

  rme_checker chk (.*);

  // receiver: random stall before each result transfer while rx_busy is set
  always @(posedge clk) begin
    int w;
    w = rx_wait;
    if (!rst_n) begin
      w = 0;
    end else if (out_tvalid && out_tready) begin
      w = rx_busy ? $urandom_range(0, 6) : 0;
    end else if (w > 0) begin
      w = w - 1;
    end
    rx_wait <= w;
    out_tready <= rst_n && (w == 0);
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 3000) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_matrix(input logic signed [15:0] r00, r02, r10, r11, r12, r20, r22);
    int gap;
    gap = tx_busy ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {r22, r20, r12, r11, r10, r02, r00};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  function automatic logic [15:0] rnd_entry();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 16'hffff));
      1: return 16'($signed(16'($urandom_range(0, 32768))) - 16'sd16384);
      2: return 16'($urandom_range(0, 40) - 20);
      default: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
    endcase
  endfunction

  function automatic logic [15:0] rnd_r10(input int th);
    int v;
    if ($urandom_range(0, 3) == 0) begin
      v = th + $urandom_range(0, 4) - 2;
      if ($urandom_range(0, 1)) v = -v;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return 16'(v);
    end
    return rnd_entry();
  endfunction

  initial begin
    int th_list [6] = '{16351, 0, 16384, 32767, 8192, 16351};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: identity, extremes, poles, threshold edges, zero vectors
    tx_busy = 1'b1;
    rx_busy = 1'b1;
    send_matrix(16384, 0, 0, 16384, 0, 0, 16384);
    send_matrix(0, 0, 0, 0, 0, 0, 0);
    send_matrix(-32768, -32768, -32768, -32768, -32768, -32768, -32768);
    send_matrix(32767, 32767, 32767, 32767, 32767, 32767, 32767);
    send_matrix(-100, 0, 0, -100, 0, 0, -100);
    send_matrix(-100, 5, 16351, -100, 0, 0, -7);
    send_matrix(-100, -5, 16352, 3, 0, 0, -7);
    send_matrix(7, 0, -16351, 3, 9, 1, 0);
    send_matrix(7, 0, -16352, 3, 9, 1, 0);
    send_matrix(0, 100, 16384, 0, -100, 100, 0);
    send_matrix(0, -100, -16384, 0, 100, -100, 0);
    send_matrix(11585, 11585, 11585, 11585, -11585, -11585, 11585);
    send_matrix(-1, -1, 1, -1, 1, 1, -1);
    send_matrix(1, 1, -1, 1, -1, -1, 1);
    send_matrix(16384, -16384, 8192, -16384, 16384, 32767, -32768);
    drain();

    foreach (th_list[p]) begin
      cfg_write({rme_pkg::RegPoleThreshold[0], 2'b00}, 32'(th_list[p]));
      if (p == 2) cfg_write(3'd4, 32'd5);   // unmapped address, ignored
      tx_busy = (p != 1);
      rx_busy = (p != 4);
      if (p == 2) send_matrix(0, 0, 16384, 0, 0, 0, 0);
      if (p == 3) begin
        // clamped asin beyond unit range; -32768 takes the south pole branch
        send_matrix(0, 0, 32767, 0, 0, 0, 0);
        send_matrix(0, 0, -32768, 0, 0, 0, 0);
        send_matrix(0, 0, 20000, 0, 0, 0, 0);
      end
      repeat (200) send_matrix(rnd_entry(), rnd_entry(), rnd_r10(th_list[p]), rnd_entry(),
                               rnd_entry(), rnd_entry(), rnd_entry());
      drain();
    end

    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
